>>> hw/rtl/stsa_pkg.sv
// Package for the station traffic share averager.
// Holds the default parameters, the state and register codes and the shared types.
// No dependencies.
`timescale 1ns / 1ps

package stsa_pkg;

    localparam int DEF_STATIONS      = 64;
    localparam int DEF_AVG_SCALE     = 12;
    localparam int DEF_WEIGHT_FACTOR = 15;
    localparam int DEF_WEIGHT_DIV    = 16;

    localparam int CNT_W  = 64;   // cumulative counter width
    localparam int DEN_W  = 66;   // exact interval total
    localparam int AVG_W  = 16;
    localparam int STEP_W = 5;    // divider step count, up to 31

    typedef enum logic [0:0] {
        REG_VOICE_WEIGHT = 1'b0,
        REG_MIN_PACKETS  = 1'b1
    } t_cfg_reg;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_LOAD,
        ST_DIFF,
        ST_SHARE,
        ST_WSHARE,
        ST_BLEND,
        ST_WBLEND,
        ST_WRITE
    } t_state;

    // One memory row per station: two snapshot slots of (normal, bulk, prio).
    typedef struct packed {
        logic [1:0][2:0][CNT_W-1:0] snap;
        logic                       sel;
        logic [AVG_W-1:0]           bulk;
        logic [AVG_W-1:0]           prio;
    } t_row;

    // Request to the shared divider. The remainder starts at rem0 (below den)
    // and the bits of low are shifted in from the top, one per step.
    typedef struct packed {
        logic              start;
        logic [DEN_W-1:0]  rem0;
        logic [DEN_W-1:0]  den;
        logic [AVG_W-1:0]  low;
        logic [STEP_W-1:0] steps;
    } t_div_req;

endpackage

>>> hw/rtl/stsa_mem.sv
// Station state memory: one row per station, one write and one registered read port.
// Depends on stsa_pkg for the row type.
`timescale 1ns / 1ps

module stsa_mem #(
    parameter int DEPTH = stsa_pkg::DEF_STATIONS,
    parameter int AW    = 6
) (
    input  logic           i_clk,
    input  logic           i_we,
    input  logic [AW-1:0]  i_waddr,
    input  stsa_pkg::t_row i_wdata,
    input  logic           i_re,
    input  logic [AW-1:0]  i_raddr,
    output stsa_pkg::t_row o_rdata
);

    stsa_pkg::t_row r_mem [DEPTH];
    stsa_pkg::t_row r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

>>> hw/rtl/stsa_div.sv
// Restoring divider, one quotient bit per cycle, used for the two share samples.
// Depends on stsa_pkg for the request type and widths.
`timescale 1ns / 1ps

module stsa_div (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  stsa_pkg::t_div_req             i_req,
    output logic                           o_done,
    output logic [stsa_pkg::AVG_W-1:0]     o_quot
);

    logic [stsa_pkg::DEN_W-1:0]  r_rem;
    logic [stsa_pkg::DEN_W-1:0]  r_den;
    logic [stsa_pkg::AVG_W-1:0]  r_low;
    logic [stsa_pkg::AVG_W-1:0]  r_quot;
    logic [stsa_pkg::STEP_W-1:0] r_cnt;
    logic                        r_run;
    logic                        r_done;
    logic [stsa_pkg::DEN_W:0]    trial;
    logic [stsa_pkg::DEN_W:0]    diff;
    logic                        fits;

    // The remainder stays below den, so the shifted trial fits one extra bit.
    assign trial = {r_rem, r_low[stsa_pkg::AVG_W-1]};
    assign diff  = trial - {1'b0, r_den};
    assign fits  = (trial >= {1'b0, r_den});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run  <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_run <= 1'b1;
                r_cnt <= i_req.steps;
            end else if (r_run) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == stsa_pkg::STEP_W'(1)) begin
                    r_run  <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_rem  <= i_req.rem0;
            r_den  <= i_req.den;
            r_low  <= i_req.low;
            r_quot <= '0;
        end else if (r_run) begin
            r_rem  <= fits ? diff[stsa_pkg::DEN_W-1:0] : trial[stsa_pkg::DEN_W-1:0];
            r_low  <= {r_low[stsa_pkg::AVG_W-2:0], 1'b0};
            r_quot <= {r_quot[stsa_pkg::AVG_W-2:0], fits};
        end
    end

    assign o_done = r_done;
    assign o_quot = r_quot;

endmodule

>>> hw/rtl/station_traffic_share_averager.sv
// Top level of the station traffic share averager: control sequencer and datapath.
// Depends on stsa_pkg, stsa_mem and stsa_div.
//
//   Channel   Signals                                  Direction  Handshake
//   report    start, busy, i_station, i_tid0..7_count  in         start & !busy
//   result    o_done, o_station_out, o_*_share,        out        o_done, one cycle
//             o_updated
//   config    i_cfg_we, i_cfg_idx, i_cfg_data          in         i_cfg_we
//
// A report below threshold passes LOAD, DIFF and WRITE before its result word goes out;
// an updating report also runs SHARE, WSHARE and BLEND for each of the two share samples,
// waiting in WSHARE on the one-bit-per-cycle divider, plus WBLEND unless a blend is direct.
// A new report can be accepted at the edge that takes the result word.
// After reset a clearing pass zeroes every row of the station memory, busy high.
// One report is in flight at a time; the result word cannot be stalled.
`timescale 1ns / 1ps

module station_traffic_share_averager #(
    parameter int STATIONS      = stsa_pkg::DEF_STATIONS,
    parameter int AVG_SCALE     = stsa_pkg::DEF_AVG_SCALE,
    parameter int WEIGHT_FACTOR = stsa_pkg::DEF_WEIGHT_FACTOR,
    parameter int WEIGHT_DIV    = stsa_pkg::DEF_WEIGHT_DIV
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [5:0]  i_station,
    input  logic [63:0] i_tid0_count,
    input  logic [63:0] i_tid1_count,
    input  logic [63:0] i_tid2_count,
    input  logic [63:0] i_tid3_count,
    input  logic [63:0] i_tid4_count,
    input  logic [63:0] i_tid5_count,
    input  logic [63:0] i_tid6_count,
    input  logic [63:0] i_tid7_count,
    input  logic        i_cfg_we,
    input  logic [0:0]  i_cfg_idx,
    input  logic [31:0] i_cfg_data,
    output logic        o_done,
    output logic [5:0]  o_station_out,
    output logic [15:0] o_bulk_share,
    output logic [15:0] o_prio_share,
    output logic        o_updated
);

    localparam int AW = (STATIONS > 1) ? $clog2(STATIONS) : 1;
    localparam logic signed [33:0] C_WF  = 34'(WEIGHT_FACTOR);
    localparam logic signed [33:0] C_WR  = 34'(WEIGHT_DIV - WEIGHT_FACTOR);
    localparam logic signed [33:0] C_SAT = 34'(65536 * WEIGHT_DIV);
    // A blend numerator below saturation is under 2^24, so a rounded-up reciprocal
    // with this shift gives the exact floor of the division by WEIGHT_DIV.
    localparam int C_SHIFT = 24 + $clog2(WEIGHT_DIV);
    localparam logic [24:0] C_RECIP =
        25'(((64'd1 << C_SHIFT) + 64'(WEIGHT_DIV) - 64'd1) / 64'(WEIGHT_DIV));

    stsa_pkg::t_state   r_state, n_state;
    stsa_pkg::t_row     rdata, r_row;
    stsa_pkg::t_div_req div_req;
    logic               div_done;
    logic [15:0]        div_quot;

    logic [7:0]   r_voice_weight;
    logic [31:0]  r_min_packets;
    logic [AW-1:0] r_clr, r_addr;
    logic [5:0]   r_station;
    logic         r_inrange;
    logic [7:0][63:0] r_tid;
    logic [2:0][63:0] r_cur;
    logic [63:0]  r_diff_b, r_diff_p;
    logic [65:0]  r_total;
    logic         r_upd, r_cls;
    logic [15:0]  r_sample;
    logic [23:0]  r_acc;
    logic         r_done;
    logic [5:0]   r_out_station;
    logic [15:0]  r_out_bulk, r_out_prio;
    logic         r_out_upd;

    logic         accept, inrange_in;
    logic [2:0][63:0] old, diff;
    logic [65:0]  total;
    logic         upd;
    logic [63:0]  num;
    logic [15:0]  avg;
    logic signed [33:0] acc_raw, acc;
    logic         direct;
    logic [15:0]  direct_val, blend_val, new_avg;
    logic [48:0]  prod;
    stsa_pkg::t_row row_load, row_blend;

    assign accept     = start && !busy;
    assign inrange_in = (32'(i_station) < STATIONS);
    assign busy       = (r_state != stsa_pkg::ST_IDLE);

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_voice_weight <= 8'd4;
            r_min_packets  <= 32'd100;
        end else if (i_cfg_we) begin
            case (stsa_pkg::t_cfg_reg'(i_cfg_idx))
                stsa_pkg::REG_VOICE_WEIGHT: r_voice_weight <= i_cfg_data[7:0];
                stsa_pkg::REG_MIN_PACKETS:  r_min_packets  <= i_cfg_data;
                default: ;
            endcase
        end
    end

    stsa_mem #(.DEPTH(STATIONS), .AW(AW)) u_mem (
        .i_clk   (i_clk),
        .i_we    ((r_state == stsa_pkg::ST_CLEAR) ||
                  ((r_state == stsa_pkg::ST_WRITE) && r_inrange)),
        .i_waddr ((r_state == stsa_pkg::ST_CLEAR) ? r_clr : r_addr),
        .i_wdata ((r_state == stsa_pkg::ST_CLEAR) ? '0 : r_row),
        .i_re    (accept),
        .i_raddr (AW'(i_station)),
        .o_rdata (rdata)
    );

    stsa_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .o_done  (div_done),
        .o_quot  (div_quot)
    );

    // Interval differences against the older slot, total kept exact.
    always_comb begin
        for (int k = 0; k < 3; k++) begin
            old[k]  = rdata.snap[~rdata.sel][k];
            diff[k] = r_cur[k] - old[k];
        end
        total = {2'b0, diff[0]} + {2'b0, diff[1]} + {2'b0, diff[2]};
        upd   = (total != '0) &&
                ((total[65:64] != 2'b0) || (total[63:0] >= 64'(r_min_packets)));
    end

    // Blend of the old average with the new sample, and the request to the divider.
    always_comb begin
        num     = r_cls ? r_diff_p : r_diff_b;
        avg     = r_cls ? r_row.prio : r_row.bulk;
        acc_raw = $signed({18'd0, avg}) * C_WF + $signed({18'd0, r_sample}) * C_WR;
        acc     = acc_raw[33] ? '0 : acc_raw;
        direct  = (avg == '0) || (acc >= C_SAT);
        direct_val = (avg == '0) ? r_sample : 16'hFFFF;
        prod       = 49'(r_acc) * 49'(C_RECIP);
        blend_val  = (prod[C_SHIFT +: 16] == '0) ? 16'd1 : prod[C_SHIFT +: 16];
        new_avg    = (r_state == stsa_pkg::ST_WBLEND) ? blend_val : direct_val;

        div_req = '0;
        if (r_state == stsa_pkg::ST_SHARE) begin
            // Start one bit down so the remainder is below the total.
            div_req.start = 1'b1;
            div_req.rem0  = {3'b0, num[63:1]};
            div_req.den   = r_total;
            div_req.low   = {num[0], 15'd0};
            div_req.steps = stsa_pkg::STEP_W'(AVG_SCALE + 1);
        end
    end

    // Row images: the loaded row with the new snapshot, and the row with one new average.
    always_comb begin
        row_load = rdata;
        row_load.snap[rdata.sel] = r_cur;
        row_blend = r_row;
        if (r_cls) begin
            row_blend.prio = new_avg;
            row_blend.sel  = ~r_row.sel;
        end else begin
            row_blend.bulk = new_avg;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= stsa_pkg::ST_CLEAR;
            r_clr   <= '0;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_done  <= (r_state == stsa_pkg::ST_WRITE);
            if (r_state == stsa_pkg::ST_CLEAR) begin
                r_clr <= r_clr + 1'b1;
            end
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            stsa_pkg::ST_CLEAR:
                if (r_clr == AW'(STATIONS - 1)) n_state = stsa_pkg::ST_IDLE;
            stsa_pkg::ST_IDLE:
                if (start) n_state = inrange_in ? stsa_pkg::ST_LOAD : stsa_pkg::ST_WRITE;
            stsa_pkg::ST_LOAD:  n_state = stsa_pkg::ST_DIFF;
            stsa_pkg::ST_DIFF:  n_state = upd ? stsa_pkg::ST_SHARE : stsa_pkg::ST_WRITE;
            stsa_pkg::ST_SHARE: n_state = stsa_pkg::ST_WSHARE;
            stsa_pkg::ST_WSHARE:
                if (div_done) n_state = stsa_pkg::ST_BLEND;
            stsa_pkg::ST_BLEND:
                if (direct) n_state = r_cls ? stsa_pkg::ST_WRITE : stsa_pkg::ST_SHARE;
                else        n_state = stsa_pkg::ST_WBLEND;
            stsa_pkg::ST_WBLEND:
                n_state = r_cls ? stsa_pkg::ST_WRITE : stsa_pkg::ST_SHARE;
            stsa_pkg::ST_WRITE: n_state = stsa_pkg::ST_IDLE;
            default:            n_state = stsa_pkg::ST_IDLE;
        endcase
    end

    // Datapath registers.
    always_ff @(posedge i_clk) begin
        case (r_state)
            stsa_pkg::ST_IDLE: begin
                r_addr    <= AW'(i_station);
                r_station <= i_station;
                r_inrange <= inrange_in;
                r_upd     <= 1'b0;
                r_cls     <= 1'b0;
                r_tid     <= {i_tid7_count, i_tid6_count, i_tid5_count, i_tid4_count,
                              i_tid3_count, i_tid2_count, i_tid1_count, i_tid0_count};
            end
            stsa_pkg::ST_LOAD: begin
                r_cur[0] <= r_tid[0] + r_tid[3];
                r_cur[1] <= r_tid[1] + r_tid[2];
                // Voice counts share one weight, so their sum is scaled once.
                r_cur[2] <= r_tid[4] + r_tid[5] +
                            64'((r_tid[6] + r_tid[7]) * r_voice_weight);
            end
            stsa_pkg::ST_DIFF: begin
                r_row    <= row_load;
                r_diff_b <= diff[1];
                r_diff_p <= diff[2];
                r_total  <= total;
                r_upd    <= upd;
            end
            stsa_pkg::ST_WSHARE:
                if (div_done) r_sample <= div_quot;
            stsa_pkg::ST_BLEND:
                if (direct) begin
                    r_cls <= 1'b1;
                    r_row <= row_blend;
                end else begin
                    r_acc <= acc[23:0];
                end
            stsa_pkg::ST_WBLEND: begin
                r_cls <= 1'b1;
                r_row <= row_blend;
            end
            stsa_pkg::ST_WRITE: begin
                r_out_station <= r_station;
                r_out_bulk    <= r_inrange ? r_row.bulk : '0;
                r_out_prio    <= r_inrange ? r_row.prio : '0;
                r_out_upd     <= r_inrange && r_upd;
            end
            default: ;
        endcase
    end

    assign o_done        = r_done;
    assign o_station_out = r_out_station;
    assign o_bulk_share  = r_out_bulk;
    assign o_prio_share  = r_out_prio;
    assign o_updated     = r_out_upd;

    // The block is idle again while its result word is out.
    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> !busy)
        else $error("block busy while its result word is out");

    // Exactly one result word per report, never two in a row.
    a_single_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |=> !o_done)
        else $error("result strobe held for more than one cycle");

    // An accepted report keeps the block busy until its result.
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
        else $error("block not busy after accepting a report");

    // Divider is never restarted while the sequencer waits on it.
    a_div_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_req.start |=> (r_state == stsa_pkg::ST_WSHARE || r_state == stsa_pkg::ST_WBLEND))
        else $error("divider started outside a wait sequence");

endmodule

>>> tb/tb_station_traffic_share_averager.sv
// Self-checking testbench for station_traffic_share_averager.
// Drives station reports and register writes, predicts every result word and checks it.
// Depends on stsa_pkg and the RTL of the block.
`timescale 1ns / 1ps

module tb_station_traffic_share_averager;

    localparam int NUM_STA   = 64;
    localparam int SCALE     = 12;
    localparam int W_FACTOR  = 15;
    localparam int W_DIV     = 16;
    localparam int QUIET     = 100;
    localparam int MAX_CYCLE = 1500000;

    typedef struct packed {
        logic [5:0]  station;
        logic [15:0] bulk;
        logic [15:0] prio;
        logic        updated;
    } t_share_word;

    logic        i_clk;
    logic        i_rst_n;
    logic        start;
    logic        busy;
    logic [5:0]  i_station;
    logic [63:0] tid_drv [8];
    logic        i_cfg_we;
    stsa_pkg::t_cfg_reg i_cfg_idx;
    logic [31:0] i_cfg_data;
    logic        o_done;
    logic [5:0]  o_station_out;
    logic [15:0] o_bulk_share;
    logic [15:0] o_prio_share;
    logic        o_updated;

    station_traffic_share_averager i_dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .start(start), .busy(busy),
        .i_station(i_station),
        .i_tid0_count(tid_drv[0]), .i_tid1_count(tid_drv[1]),
        .i_tid2_count(tid_drv[2]), .i_tid3_count(tid_drv[3]),
        .i_tid4_count(tid_drv[4]), .i_tid5_count(tid_drv[5]),
        .i_tid6_count(tid_drv[6]), .i_tid7_count(tid_drv[7]),
        .i_cfg_we(i_cfg_we), .i_cfg_idx(i_cfg_idx), .i_cfg_data(i_cfg_data),
        .o_done(o_done), .o_station_out(o_station_out), .o_bulk_share(o_bulk_share),
        .o_prio_share(o_prio_share), .o_updated(o_updated)
    );

    // Mirror of the block state and registers.
    logic [63:0] snap_mirror [NUM_STA][2][3];
    logic        slot_mirror [NUM_STA];
    logic [15:0] bulk_mirror [NUM_STA];
    logic [15:0] prio_mirror [NUM_STA];
    logic [7:0]  voice_weight_cfg;
    logic [31:0] min_packets_cfg;

    t_share_word expected_shares [$];
    int          mismatches;
    int          cycle_count;
    int          idle_max;
    logic [63:0] traffic_cum [NUM_STA][8];

    function automatic logic [15:0] share_sample(logic [63:0] part, logic [65:0] total);
        logic [127:0] q;
        q = ({64'd0, part} << SCALE) / {62'd0, total};
        return q[15:0];
    endfunction

    function automatic logic [15:0] blend_average(logic [15:0] avg, logic [15:0] sample);
        logic [31:0] acc;
        if (avg == 16'd0) begin
            return sample;
        end
        acc = (32'(avg) * W_FACTOR + 32'(sample) * (W_DIV - W_FACTOR)) / W_DIV;
        if (acc > 32'd65535) acc = 32'd65535;
        if (acc == 32'd0) acc = 32'd1;
        return acc[15:0];
    endfunction

    function automatic t_share_word predict_shares(logic [5:0] st);
        logic [63:0] cls [3];
        logic [63:0] diff [3];
        logic [65:0] total;
        logic        sel;
        t_share_word w;
        cls[0] = tid_drv[0] + tid_drv[3];
        cls[1] = tid_drv[1] + tid_drv[2];
        cls[2] = tid_drv[4] + tid_drv[5] + tid_drv[6] * 64'(voice_weight_cfg)
               + tid_drv[7] * 64'(voice_weight_cfg);
        sel = slot_mirror[st];
        total = '0;
        for (int k = 0; k < 3; k++) begin
            snap_mirror[st][sel][k] = cls[k];
            diff[k] = cls[k] - snap_mirror[st][~sel][k];
            total = total + 66'(diff[k]);
        end
        w.station = st;
        w.updated = 1'b0;
        if (total != 66'd0 && total >= 66'(min_packets_cfg)) begin
            bulk_mirror[st] = blend_average(bulk_mirror[st], share_sample(diff[1], total));
            prio_mirror[st] = blend_average(prio_mirror[st], share_sample(diff[2], total));
            slot_mirror[st] = ~sel;
            w.updated = 1'b1;
        end
        w.bulk = bulk_mirror[st];
        w.prio = prio_mirror[st];
        return w;
    endfunction

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Accepted reports are predicted at the edge that takes them.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (i_rst_n && start && !busy) begin
            expected_shares.push_back(predict_shares(i_station));
        end
    end

    // Every result word is compared with the oldest prediction.
    always @(posedge i_clk) begin
        t_share_word exp_w;
        if (i_rst_n && o_done) begin
            if (expected_shares.size() == 0) begin
                $error("result word for station %0d with nothing expected", o_station_out);
                mismatches++;
            end else begin
                exp_w = expected_shares.pop_front();
                if (o_station_out !== exp_w.station) begin
                    $error("station_out: expected %0d, got %0d", exp_w.station, o_station_out);
                    mismatches++;
                end
                if (o_bulk_share !== exp_w.bulk) begin
                    $error("bulk_share: expected %0d, got %0d", exp_w.bulk, o_bulk_share);
                    mismatches++;
                end
                if (o_prio_share !== exp_w.prio) begin
                    $error("prio_share: expected %0d, got %0d", exp_w.prio, o_prio_share);
                    mismatches++;
                end
                if (o_updated !== exp_w.updated) begin
                    $error("updated: expected %0d, got %0d", exp_w.updated, o_updated);
                    mismatches++;
                end
            end
        end
    end

    initial begin
        wait (cycle_count >= MAX_CYCLE);
        $display("FAILURE");
        $finish;
    end

    task automatic idle_gap();
        int n;
        int pick;
        pick = $urandom_range(0, 99);
        if (idle_max == 0 || pick < 55) n = 0;
        else if (pick < 92) n = $urandom_range(1, 3);
        else n = $urandom_range(8, idle_max);
        if (n > 0) begin
            @(negedge i_clk);
            start = 1'b0;
            // The station field wanders while start is low.
            i_station = 6'($urandom);
            repeat (n - 1) @(negedge i_clk);
        end
    endtask

    task automatic send_report(logic [5:0] st, logic [63:0] cnt [8]);
        @(negedge i_clk);
        start = 1'b1;
        i_station = st;
        for (int t = 0; t < 8; t++) tid_drv[t] = cnt[t];
        do @(posedge i_clk); while (!(start && !busy));
        idle_gap();
    endtask

    // Registers are only written once every result word has come back.
    task automatic write_register(stsa_pkg::t_cfg_reg idx, logic [31:0] data);
        @(negedge i_clk);
        start = 1'b0;
        wait (expected_shares.size() == 0);
        repeat (QUIET) @(posedge i_clk);
        @(negedge i_clk);
        i_cfg_we = 1'b1;
        i_cfg_idx = idx;
        i_cfg_data = data;
        @(posedge i_clk);
        if (idx == stsa_pkg::REG_VOICE_WEIGHT) voice_weight_cfg = data[7:0];
        else min_packets_cfg = data;
        @(negedge i_clk);
        i_cfg_we = 1'b0;
    endtask

    task automatic send_fill(logic [5:0] st, logic [63:0] v);
        logic [63:0] cnt [8];
        for (int t = 0; t < 8; t++) cnt[t] = v;
        send_report(st, cnt);
    endtask

    task automatic test_extremes();
        logic [63:0] cnt [8];
        send_fill(6'd0, 64'd0);                  // zero interval total
        send_fill(6'd0, 64'd0);
        send_fill(6'd63, '1);                    // all ones, class sums wrap
        send_fill(6'd63, 64'd0);                 // counters go backwards
        for (int t = 0; t < 8; t++) cnt[t] = 64'd0;
        cnt[1] = 64'd5000;                       // bulk only
        send_report(6'd1, cnt);
        cnt[1] = 64'd5000; cnt[6] = 64'd3000;    // voice only in this interval
        send_report(6'd1, cnt);
        send_report(6'd1, cnt);                  // no traffic since last report
        for (int t = 0; t < 8; t++) cnt[t] = 64'd1 << (8 * t);
        send_report(6'd2, cnt);
    endtask

    task automatic test_thresholds();
        logic [63:0] cnt [8];
        write_register(stsa_pkg::REG_MIN_PACKETS, 32'hFFFF_FFFF);
        for (int t = 0; t < 8; t++) cnt[t] = 64'd0;
        cnt[0] = 64'hFFFF_FFFE;                  // just below
        send_report(6'd3, cnt);
        cnt[0] = 64'h1_FFFF_FFFE;                // interval above threshold
        send_report(6'd3, cnt);
        write_register(stsa_pkg::REG_MIN_PACKETS, 32'd1);
        cnt[4] = 64'd1;
        send_report(6'd3, cnt);
        cnt[4] = 64'd2;
        send_report(6'd3, cnt);
    endtask

    task automatic test_voice_weight();
        logic [63:0] cnt [8];
        for (int t = 0; t < 8; t++) cnt[t] = 64'd0;
        write_register(stsa_pkg::REG_VOICE_WEIGHT, 32'd0);
        cnt[6] = 64'd1000; cnt[7] = 64'd1000; cnt[2] = 64'd100;
        send_report(6'd4, cnt);
        write_register(stsa_pkg::REG_VOICE_WEIGHT, 32'd255);
        cnt[6] = 64'd2000; cnt[7] = 64'd2000; cnt[2] = 64'd200;
        send_report(6'd4, cnt);
        cnt[7] = '1;                             // product wraps
        send_report(6'd4, cnt);
    endtask

    task automatic traffic_phase(int items, int max_inc);
        logic [63:0] cnt [8];
        logic [5:0]  st;
        int          kind;
        for (int i = 0; i < items; i++) begin
            kind = $urandom_range(0, 99);
            st = (kind < 60) ? 6'($urandom_range(0, 7)) : 6'($urandom);
            for (int t = 0; t < 8; t++) begin
                if (kind < 88) begin
                    traffic_cum[st][t] += 64'($urandom_range(0, max_inc));
                end else if (kind < 95) begin
                    traffic_cum[st][t] = {$urandom, $urandom};
                end else begin
                    traffic_cum[st][t] += 64'($urandom_range(0, 3)) << $urandom_range(0, 63);
                end
                cnt[t] = traffic_cum[st][t];
            end
            // Stretches with back-to-back reports.
            if (i % 200 == 100) idle_max = 0;
            if (i % 200 == 150) idle_max = 40;
            send_report(st, cnt);
        end
    endtask

    task automatic test_random_traffic();
        write_register(stsa_pkg::REG_VOICE_WEIGHT, 32'd4);
        write_register(stsa_pkg::REG_MIN_PACKETS, 32'd100);
        traffic_phase(450, 60);
        write_register(stsa_pkg::REG_VOICE_WEIGHT, 32'd255);
        write_register(stsa_pkg::REG_MIN_PACKETS, 32'd1);
        traffic_phase(300, 20);
        write_register(stsa_pkg::REG_VOICE_WEIGHT, 32'd0);
        write_register(stsa_pkg::REG_MIN_PACKETS, 32'd5000);
        traffic_phase(300, 2000);
        write_register(stsa_pkg::REG_VOICE_WEIGHT, 32'($urandom_range(1, 254)));
        write_register(stsa_pkg::REG_MIN_PACKETS, 32'($urandom_range(2, 400)));
        traffic_phase(280, 100);
    endtask

    initial begin
        mismatches = 0;
        cycle_count = 0;
        idle_max = 40;
        i_rst_n = 1'b0;
        start = 1'b0;
        i_station = '0;
        for (int t = 0; t < 8; t++) tid_drv[t] = '0;
        i_cfg_we = 1'b0;
        i_cfg_idx = stsa_pkg::REG_VOICE_WEIGHT;
        i_cfg_data = '0;
        voice_weight_cfg = 8'd4;
        min_packets_cfg = 32'd100;
        for (int s = 0; s < NUM_STA; s++) begin
            slot_mirror[s] = 1'b0;
            bulk_mirror[s] = '0;
            prio_mirror[s] = '0;
            for (int t = 0; t < 8; t++) traffic_cum[s][t] = '0;
            for (int k = 0; k < 6; k++) snap_mirror[s][k / 3][k % 3] = '0;
        end
        repeat (9) @(negedge i_clk);
        i_rst_n = 1'b1;

        test_extremes();
        test_thresholds();
        test_voice_weight();
        test_random_traffic();

        @(negedge i_clk);
        start = 1'b0;
        wait (expected_shares.size() == 0);
        repeat (QUIET) @(posedge i_clk);
        if (mismatches == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule
